@@ rtl/kmlf_pkg.sv @@
package kmlf_pkg;

  localparam logic [6:0]  MSG_MAX  = 7'd80;
  localparam logic [16:0] CODE_SAT = 17'd65536;
  localparam logic [7:0]  CH_CR    = 8'd13;
  localparam logic [7:0]  CH_LF    = 8'd10;
  localparam logic [7:0]  CH_ZERO  = 8'd48;
  localparam logic [7:0]  CH_NINE  = 8'd57;

  localparam int unsigned KMLF_QDEPTH = 2;

  typedef enum logic [1:0] {
    KIND_CHAR      = 2'd0,
    KIND_FOUND     = 2'd1,
    KIND_NOT_FOUND = 2'd2
  } kmlf_kind_e;

  typedef struct packed {
    kmlf_kind_e  kind;
    logic [7:0]  message_char;
    logic        last;
  } kmlf_res_t;

  typedef struct packed {
    logic      two;
    kmlf_res_t first;
    kmlf_res_t second;
  } kmlf_entry_t;

endpackage

@@ rtl/kmlf_in_if.sv @@
interface kmlf_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       end_of_stream;

  modport source (output valid, output text_byte, output end_of_stream, input ready);
  modport sink   (input valid, input text_byte, input end_of_stream, output ready);
endinterface

@@ rtl/kmlf_out_if.sv @@
interface kmlf_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [7:0] message_char;
  logic       last;

  modport source (output valid, output kind, output message_char, output last, input ready);
  modport sink   (input valid, input kind, input message_char, input last, output ready);
endinterface

@@ rtl/kmlf_fifo.sv @@
module kmlf_fifo (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  kmlf_pkg::kmlf_entry_t entry_i,
  output logic                 full_o,
  input  logic                 pop_i,
  output logic                 valid_o,
  output kmlf_pkg::kmlf_entry_t entry_o
);
  import kmlf_pkg::*;

  localparam int unsigned PTR_W = (KMLF_QDEPTH > 1) ? $clog2(KMLF_QDEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(KMLF_QDEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(KMLF_QDEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(KMLF_QDEPTH);

  kmlf_entry_t      mem_q [KMLF_QDEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;

  assign full_o  = (cnt_q == CNT_FULL);
  assign valid_o = (cnt_q != '0);
  assign entry_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

endmodule

@@ rtl/kmlf_front.sv @@
module kmlf_front (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [15:0]           cfg_wdata_i,
  kmlf_in_if.sink               text_i,
  input  logic                  full_i,
  output logic                  push_o,
  output kmlf_pkg::kmlf_entry_t entry_o
);
  import kmlf_pkg::*;

  typedef struct packed {
    logic        in_message;
    logic [16:0] code_value;
    logic        line_matches;
    logic [6:0]  chars_emitted;
    logic        search_done;
  } scan_t;

  typedef struct packed {
    scan_t     st;
    logic      hit;
    kmlf_res_t res;
  } step_t;

  localparam kmlf_res_t RES_NONE = '{kind: KIND_CHAR, message_char: 8'd0, last: 1'b0};
  localparam kmlf_res_t RES_NF   = '{kind: KIND_NOT_FOUND, message_char: 8'd0, last: 1'b1};

  function automatic logic is_term(logic [7:0] b);
    return (b == CH_CR) || (b == CH_LF);
  endfunction

  function automatic step_t take(scan_t s, logic [7:0] b, logic [15:0] wc);
    step_t       r;
    logic [19:0] code_w;
    logic [19:0] prod;
    logic [7:0]  digit;
    r.st   = s;
    r.hit  = 1'b0;
    r.res  = RES_NONE;
    code_w = {3'b000, s.code_value};
    digit  = b - CH_ZERO;
    prod   = (code_w << 3) + (code_w << 1) + {16'd0, digit[3:0]};
    if (s.in_message) begin
      if (is_term(b)) begin
        if (s.line_matches) begin
          r.hit            = 1'b1;
          r.res            = '{kind: KIND_FOUND, message_char: 8'd0, last: 1'b1};
          r.st.search_done = 1'b1;
        end else begin
          r.st.in_message    = 1'b0;
          r.st.code_value    = '0;
          r.st.line_matches  = 1'b0;
          r.st.chars_emitted = '0;
        end
      end else if (s.line_matches && (s.chars_emitted < MSG_MAX)) begin
        r.hit              = 1'b1;
        r.res              = '{kind: KIND_CHAR, message_char: b, last: 1'b0};
        r.st.chars_emitted = s.chars_emitted + 1'b1;
      end
    end else if ((b < CH_ZERO) || (b > CH_NINE)) begin
      if (s.code_value != '0) begin
        r.st.in_message    = 1'b1;
        r.st.line_matches  = (s.code_value == {1'b0, wc});
        r.st.chars_emitted = '0;
      end
    end else begin
      r.st.code_value = (prod > {3'b000, CODE_SAT}) ? CODE_SAT : prod[16:0];
    end
    return r;
  endfunction

  scan_t       scan_q, scan_d;
  logic [15:0] wanted_code_q;
  step_t       s1, s2;
  logic        do2, nf, accept;

  assign text_i.ready = !full_i;
  assign accept       = text_i.valid && text_i.ready;

  always_comb begin
    s1 = '{st: scan_q, hit: 1'b0, res: RES_NONE};
    if (!scan_q.search_done) begin
      s1 = take(scan_q, text_i.text_byte, wanted_code_q);
    end
    do2 = text_i.end_of_stream && !s1.st.search_done && !is_term(text_i.text_byte);
    s2  = '{st: s1.st, hit: 1'b0, res: RES_NONE};
    if (do2) begin
      s2 = take(s1.st, CH_LF, wanted_code_q);
    end
    nf     = text_i.end_of_stream && !s2.st.search_done;
    scan_d = text_i.end_of_stream ? '0 : s2.st;

    entry_o.two    = (s1.hit && s2.hit) || (s1.hit && nf) || (s2.hit && nf);
    entry_o.first  = s1.hit ? s1.res : (s2.hit ? s2.res : RES_NF);
    entry_o.second = (s1.hit && s2.hit) ? s2.res : RES_NF;
    push_o         = accept && (s1.hit || s2.hit || nf);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_q        <= '0;
      wanted_code_q <= '0;
    end else begin
      if (accept) begin
        scan_q <= scan_d;
      end
      if (cfg_we_i) begin
        wanted_code_q <= cfg_wdata_i;
      end
    end
  end

endmodule

@@ rtl/kmlf_emit.sv @@
module kmlf_emit (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  valid_i,
  input  kmlf_pkg::kmlf_entry_t entry_i,
  output logic                  pop_o,
  kmlf_out_if.source            result_o
);
  import kmlf_pkg::*;

  logic      sel_q, sel_d;
  logic      xfer;
  kmlf_res_t cur;

  assign cur                   = sel_q ? entry_i.second : entry_i.first;
  assign result_o.valid        = valid_i;
  assign result_o.kind         = cur.kind;
  assign result_o.message_char = cur.message_char;
  assign result_o.last         = cur.last;
  assign xfer                  = result_o.valid && result_o.ready;

  always_comb begin
    sel_d = sel_q;
    pop_o = 1'b0;
    if (xfer) begin
      if (!sel_q && entry_i.two) begin
        sel_d = 1'b1;
      end else begin
        sel_d = 1'b0;
        pop_o = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sel_q <= 1'b0;
    end else begin
      sel_q <= sel_d;
    end
  end

endmodule

@@ rtl/keyed_message_line_finder.sv @@
// Channel    Role     Payload                               Transfer when
// text_i     sink     text_byte[7:0], end_of_stream         valid && ready
// result_o   source   kind[1:0], message_char[7:0], last    valid && ready
// cfg        write    cfg_wdata_i[15:0] (wanted_code)       cfg_we_i
//
// One text byte per cycle while the queue has room; each byte yields at most one result, except a final
// byte that may yield two, which are presented one after the other.
// A two-entry queue parts the scanner from the result stage; text_i.ready drops
// only while that queue is full. Results are written into the queue on transfer and shown from its head.
// Reset clears the scan state and wanted_code; no clearing pass.
module keyed_message_line_finder (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,
  kmlf_in_if.sink     text_i,
  kmlf_out_if.source  result_o
);
  import kmlf_pkg::*;

  logic        push, full, pop, q_valid;
  kmlf_entry_t push_entry, head_entry;

  kmlf_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .text_i      (text_i),
    .full_i      (full),
    .push_o      (push),
    .entry_o     (push_entry)
  );

  kmlf_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (push_entry),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (q_valid),
    .entry_o (head_entry)
  );

  kmlf_emit u_emit (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (q_valid),
    .entry_i  (head_entry),
    .pop_o    (pop),
    .result_o (result_o)
  );

`ifndef NO_ASSERTIONS
  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> !full) else $error("push into full queue");

  a_pair_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && push_entry.two) |->
      (push_entry.first.kind == KIND_CHAR) && push_entry.second.last)
    else $error("two-result entry malformed");

  a_pop_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> (q_valid && result_o.ready)) else $error("pop without transfer");

  a_kind_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_o.valid && result_o.ready) |->
      (result_o.last == (result_o.kind != KIND_CHAR)))
    else $error("last flag disagrees with kind");
`endif

endmodule
